// ===== hw/rtl/wtnm_pkg.sv =====
// ----------------------------------------------------------------------------
// wtnm_pkg
// Shared types, codes and the wall template table for the wall tile matcher.
// ----------------------------------------------------------------------------
package wtnm_pkg;

   localparam int CELL_COUNT     = 9;
   localparam int CODE_WIDTH     = 4;
   localparam int TEMPLATE_COUNT = 46;
   localparam int SPRITE_WIDTH   = 6;
   localparam int CENTRE_CELL    = 4;

   // content codes
   localparam logic [CODE_WIDTH-1:0] CELL_PATH_MAX   = 4'd4;
   localparam logic [CODE_WIDTH-1:0] CELL_WALL       = 4'd5;
   localparam logic [CODE_WIDTH-1:0] CELL_GHOST_WALL = 4'd6;
   localparam logic [CODE_WIDTH-1:0] CELL_GHOST_DOOR = 4'd7;

   localparam logic [SPRITE_WIDTH-1:0] DOOR_SPRITE = 6'd21;

   // template cell kinds
   typedef enum logic [2:0] {
      K_ANY = 3'd0,  // anything
      K_PTH = 3'd1,  // open path, in bounds
      K_OUT = 3'd2,  // out of bounds
      K_WAL = 3'd3,  // wall
      K_GHW = 3'd4,  // ghost wall
      K_AWL = 3'd5,  // wall or ghost wall
      K_WOO = 3'd6,  // any wall or out of bounds
      K_DOR = 3'd7   // ghost door
   } cell_kind_type;

   // one bit per kind: does this cell satisfy that kind
   typedef logic [7:0] cell_match_type;

   typedef struct packed {
      logic [SPRITE_WIDTH-1:0] sprite;
      cell_kind_type [0:CELL_COUNT-1] kinds;
   } tmpl_type;

   typedef struct packed {
      logic                    present;
      logic                    matched;
      logic [SPRITE_WIDTH-1:0] number;
      logic                    door;
   } result_type;

   // priority order: first matching entry wins
   localparam tmpl_type TEMPLATES [TEMPLATE_COUNT] = '{
      '{6'd0,  '{K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL}},
      '{6'd1,  '{K_ANY, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_ANY, K_WAL, K_WAL}},
      '{6'd2,  '{K_ANY, K_PTH, K_ANY, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL}},
      '{6'd3,  '{K_WAL, K_WAL, K_ANY, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_ANY}},
      '{6'd4,  '{K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_ANY, K_PTH, K_ANY}},
      '{6'd5,  '{K_PTH, K_PTH, K_PTH, K_PTH, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL}},
      '{6'd6,  '{K_PTH, K_PTH, K_PTH, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_PTH}},
      '{6'd7,  '{K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_PTH, K_PTH, K_PTH, K_PTH}},
      '{6'd8,  '{K_PTH, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_PTH, K_PTH, K_PTH}},
      '{6'd9,  '{K_PTH, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL}},
      '{6'd10, '{K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL}},
      '{6'd11, '{K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_PTH}},
      '{6'd12, '{K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL}},
      '{6'd17, '{K_PTH, K_PTH, K_ANY, K_PTH, K_WAL, K_WOO, K_ANY, K_WAL, K_OUT}},
      '{6'd18, '{K_ANY, K_PTH, K_PTH, K_WOO, K_WAL, K_PTH, K_OUT, K_WAL, K_ANY}},
      '{6'd19, '{K_OUT, K_WAL, K_ANY, K_WOO, K_WAL, K_PTH, K_ANY, K_PTH, K_PTH}},
      '{6'd20, '{K_ANY, K_WAL, K_OUT, K_PTH, K_WAL, K_WOO, K_PTH, K_PTH, K_ANY}},
      '{6'd13, '{K_ANY, K_ANY, K_ANY, K_PTH, K_AWL, K_OUT, K_ANY, K_ANY, K_ANY}},
      '{6'd14, '{K_ANY, K_PTH, K_ANY, K_ANY, K_AWL, K_ANY, K_ANY, K_OUT, K_ANY}},
      '{6'd15, '{K_ANY, K_ANY, K_ANY, K_OUT, K_AWL, K_PTH, K_ANY, K_ANY, K_ANY}},
      '{6'd16, '{K_ANY, K_OUT, K_ANY, K_ANY, K_AWL, K_ANY, K_ANY, K_PTH, K_ANY}},
      '{6'd21, '{K_ANY, K_ANY, K_ANY, K_ANY, K_DOR, K_ANY, K_ANY, K_ANY, K_ANY}},
      '{6'd22, '{K_PTH, K_WAL, K_ANY, K_WAL, K_WAL, K_OUT, K_ANY, K_OUT, K_OUT}},
      '{6'd23, '{K_ANY, K_WAL, K_PTH, K_OUT, K_WAL, K_WAL, K_OUT, K_OUT, K_ANY}},
      '{6'd24, '{K_OUT, K_OUT, K_ANY, K_OUT, K_WAL, K_WAL, K_ANY, K_WAL, K_PTH}},
      '{6'd25, '{K_ANY, K_OUT, K_OUT, K_WAL, K_WAL, K_OUT, K_PTH, K_WAL, K_ANY}},
      '{6'd26, '{K_PTH, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT}},
      '{6'd27, '{K_OUT, K_WAL, K_PTH, K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL}},
      '{6'd28, '{K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_PTH}},
      '{6'd29, '{K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT, K_PTH, K_WAL, K_OUT}},
      '{6'd30, '{K_PTH, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_OUT, K_OUT, K_OUT}},
      '{6'd31, '{K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_WAL, K_OUT, K_OUT, K_OUT}},
      '{6'd32, '{K_OUT, K_OUT, K_OUT, K_WAL, K_WAL, K_WAL, K_WAL, K_WAL, K_PTH}},
      '{6'd33, '{K_OUT, K_OUT, K_OUT, K_WAL, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL}},
      '{6'd34, '{K_PTH, K_PTH, K_PTH, K_PTH, K_GHW, K_GHW, K_PTH, K_GHW, K_OUT}},
      '{6'd35, '{K_PTH, K_PTH, K_PTH, K_GHW, K_GHW, K_PTH, K_OUT, K_GHW, K_PTH}},
      '{6'd36, '{K_OUT, K_GHW, K_PTH, K_GHW, K_GHW, K_PTH, K_PTH, K_PTH, K_PTH}},
      '{6'd37, '{K_PTH, K_GHW, K_OUT, K_PTH, K_GHW, K_GHW, K_PTH, K_PTH, K_PTH}},
      '{6'd38, '{K_OUT, K_PTH, K_ANY, K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL}},
      '{6'd39, '{K_ANY, K_PTH, K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT}},
      '{6'd40, '{K_OUT, K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT, K_PTH, K_ANY}},
      '{6'd41, '{K_WAL, K_WAL, K_OUT, K_WAL, K_WAL, K_OUT, K_ANY, K_PTH, K_OUT}},
      '{6'd42, '{K_OUT, K_OUT, K_OUT, K_PTH, K_WAL, K_WAL, K_ANY, K_WAL, K_WAL}},
      '{6'd43, '{K_OUT, K_OUT, K_OUT, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_ANY}},
      '{6'd44, '{K_ANY, K_WAL, K_WAL, K_PTH, K_WAL, K_WAL, K_OUT, K_OUT, K_OUT}},
      '{6'd45, '{K_WAL, K_WAL, K_ANY, K_WAL, K_WAL, K_PTH, K_OUT, K_OUT, K_OUT}}
   };

endpackage

// ===== hw/rtl/wtnm_cell_classify.sv =====
// ----------------------------------------------------------------------------
// wtnm_cell_classify
// Decodes each of the nine cells into one match bit per template cell kind.
// ----------------------------------------------------------------------------
module wtnm_cell_classify (
   input  logic [wtnm_pkg::CELL_COUNT*wtnm_pkg::CODE_WIDTH-1:0] cell_contents,
   input  logic [wtnm_pkg::CELL_COUNT-1:0]                      cell_out_of_bounds,
   output wtnm_pkg::cell_match_type [0:wtnm_pkg::CELL_COUNT-1]  cell_match
);
   import wtnm_pkg::*;

   always_comb begin
      logic [CODE_WIDTH-1:0] code;
      logic                  oob;
      logic                  any_wall;
      for (int i = 0; i < CELL_COUNT; i++) begin
         code     = cell_contents[i*CODE_WIDTH +: CODE_WIDTH];
         oob      = cell_out_of_bounds[i];
         any_wall = (code == CELL_WALL) || (code == CELL_GHOST_WALL);
         cell_match[i]        = '0;
         cell_match[i][K_ANY] = 1'b1;
         cell_match[i][K_PTH] = !oob && (code <= CELL_PATH_MAX);
         cell_match[i][K_OUT] = oob;
         cell_match[i][K_WAL] = (code == CELL_WALL);
         cell_match[i][K_GHW] = (code == CELL_GHOST_WALL);
         cell_match[i][K_AWL] = any_wall;
         cell_match[i][K_WOO] = any_wall || oob;
         cell_match[i][K_DOR] = (code == CELL_GHOST_DOOR);
      end
   end

endmodule

// ===== hw/rtl/wtnm_template_match.sv =====
// ----------------------------------------------------------------------------
// wtnm_template_match
// Compares all templates in parallel and picks the first hit in table order.
// ----------------------------------------------------------------------------
module wtnm_template_match (
   input  wtnm_pkg::cell_match_type [0:wtnm_pkg::CELL_COUNT-1] cell_match,
   input  logic [wtnm_pkg::CODE_WIDTH-1:0]                     centre_code,
   output wtnm_pkg::result_type                                result
);
   import wtnm_pkg::*;

   logic [TEMPLATE_COUNT-1:0] hit;
   logic                      present;
   logic                      found;
   logic [SPRITE_WIDTH-1:0]   sprite;

   always_comb begin
      for (int t = 0; t < TEMPLATE_COUNT; t++) begin
         hit[t] = 1'b1;
         for (int i = 0; i < CELL_COUNT; i++) begin
            hit[t] = hit[t] & cell_match[i][TEMPLATES[t].kinds[i]];
         end
      end
   end

   // walk from the back so the lowest table entry wins
   always_comb begin
      found  = 1'b0;
      sprite = '0;
      for (int t = TEMPLATE_COUNT - 1; t >= 0; t--) begin
         if (hit[t]) begin
            found  = 1'b1;
            sprite = TEMPLATES[t].sprite;
         end
      end
   end

   assign present = (centre_code == CELL_WALL) || (centre_code == CELL_GHOST_WALL)
                    || (centre_code == CELL_GHOST_DOOR);

   always_comb begin
      result.present = present;
      result.matched = present && found;
      result.number  = (present && found) ? sprite : '0;
      result.door    = present && found && (sprite == DOOR_SPRITE);
   end

endmodule

// ===== hw/rtl/wall_tile_neighbourhood_matcher_top.sv =====
// ----------------------------------------------------------------------------
// wall_tile_neighbourhood_matcher_top
// Picks the wall sprite for one maze tile from its 3x3 neighbourhood.
// ----------------------------------------------------------------------------
// Pipeline: the input register, then the template compare into the result
//   register that drives the response outputs.
// Throughput: 1 tile per cycle; busy is never raised, a transfer can start
//   on every edge. The receiver cannot stall; rsp_strobe marks each result.
// Reset: synchronous, active high; clears the two valid flags, so no
//   strobe appears until a new transfer has gone through.
// ----------------------------------------------------------------------------
module wall_tile_neighbourhood_matcher_top (
   input  logic                                                 clock,
   input  logic                                                 reset,
   // request channel
   input  logic                                                 start,
   output logic                                                 busy,
   input  logic [wtnm_pkg::CELL_COUNT*wtnm_pkg::CODE_WIDTH-1:0] req_cell_contents,
   input  logic [wtnm_pkg::CELL_COUNT-1:0]                      req_cell_out_of_bounds,
   // response channel
   output logic                                                 rsp_strobe,
   output logic                                                 rsp_sprite_present,
   output logic                                                 rsp_sprite_matched,
   output logic [wtnm_pkg::SPRITE_WIDTH-1:0]                    rsp_sprite_number,
   output logic                                                 rsp_door_sprite
);
   import wtnm_pkg::*;

   logic                               accept;

   // input stage
   logic                               req_valid_ff;
   logic [CELL_COUNT*CODE_WIDTH-1:0]   contents_ff;
   logic [CELL_COUNT-1:0]              oob_ff;

   // result stage
   logic                               rsp_valid_ff;
   result_type                         result_in;
   result_type                         result_ff;

   cell_match_type [0:CELL_COUNT-1]    cell_match;

   // Every stage moves on every edge, so nothing ever needs to push back.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   // payload registers: no reset needed, the valid flags qualify them
   always_ff @(posedge clock) begin
      if (accept) begin
         contents_ff <= req_cell_contents;
         oob_ff      <= req_cell_out_of_bounds;
      end
      if (req_valid_ff) begin
         result_ff <= result_in;
      end
   end

   // per-cell decode: one match bit for each template cell kind
   wtnm_cell_classify u_classify (
      .cell_contents      (contents_ff),
      .cell_out_of_bounds (oob_ff),
      .cell_match         (cell_match)
   );

   // all templates compared at once, first hit in table order wins
   wtnm_template_match u_match (
      .cell_match  (cell_match),
      .centre_code (contents_ff[CENTRE_CELL*CODE_WIDTH +: CODE_WIDTH]),
      .result      (result_in)
   );

   assign rsp_strobe         = rsp_valid_ff;
   assign rsp_sprite_present = result_ff.present;
   assign rsp_sprite_matched = result_ff.matched;
   assign rsp_sprite_number  = result_ff.number;
   assign rsp_door_sprite    = result_ff.door;

endmodule
